// ----- rtl/srk_pkg.sv -----
`default_nettype none

package srk_pkg;

    localparam int POP_W     = 32;
    localparam int RATE_W    = 20;
    localparam int RATE_FRAC = 16;
    localparam int H_W       = 16;
    localparam int H_FRAC    = 16;
    localparam int N_W       = POP_W + 2;
    localparam int REM_W     = N_W + 1;
    localparam int Q_W       = POP_W + 1;
    localparam int DIV_STEPS = POP_W;
    localparam int X_W       = POP_W + RATE_W - RATE_FRAC;
    localparam int K_W       = X_W + 1;
    localparam int SUM_W     = K_W + 3;
    localparam int MAG_W     = SUM_W - 1;
    localparam int W3_W      = SUM_W - 2;
    localparam int D3_STEP   = 8;
    localparam int D3_STAGES = (W3_W + D3_STEP - 1) / D3_STEP;
    localparam int NCOMP     = 3;

    localparam int CFG_W = 2;
    localparam logic [CFG_W-1:0] CFG_BETA  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ALPHA = 2'd1;
    localparam logic [CFG_W-1:0] CFG_STEP  = 2'd2;
    localparam logic [H_W-1:0]   H_RESET   = 16'd6554;

    localparam int C_S = 0;
    localparam int C_I = 1;
    localparam int C_R = 2;

    typedef logic [POP_W-1:0] t_pop;
    typedef t_pop [NCOMP-1:0] t_tri;
    typedef logic [K_W-1:0] t_k;
    typedef t_k [NCOMP-1:0] t_ktri;

    typedef struct packed {
        t_tri  p;
        t_ktri k1;
        t_ktri k2;
        t_ktri k3;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/srk_deriv.sv -----
`default_nettype none

module srk_deriv import srk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_tri              i_pt,
    input  t_side             i_side,
    input  logic [RATE_W-1:0] i_beta,
    input  logic [RATE_W-1:0] i_alpha,
    output logic              o_vld,
    output t_ktri             o_k,
    output t_side             o_side
);

    // restoring divider for s/n, one quotient bit per stage
    logic             r_dv_vld [0:DIV_STEPS];
    logic [REM_W-1:0] r_rem    [0:DIV_STEPS];
    logic [POP_W-1:0] r_q      [0:DIV_STEPS];
    logic [N_W-1:0]   r_n      [0:DIV_STEPS];
    t_pop             r_i      [0:DIV_STEPS];
    logic             r_full   [0:DIV_STEPS];
    logic             r_nz     [0:DIV_STEPS];
    t_side            r_dside  [0:DIV_STEPS];

    logic [REM_W-1:0] n_rem [1:DIV_STEPS];
    logic [POP_W-1:0] n_q   [1:DIV_STEPS];
    logic [N_W-1:0]   n_sum;

    logic             r_m1_vld;
    logic [POP_W-1:0] r_t;
    logic [X_W-1:0]   r_y;
    logic             r_m1_nz;
    t_side            r_m1_side;

    logic             r_m2_vld;
    logic [X_W-1:0]   r_x;
    logic [X_W-1:0]   r_y2;
    t_side            r_m2_side;

    logic [Q_W-1:0]          n_qq;
    logic [POP_W+Q_W-1:0]    n_pt;
    logic [POP_W+RATE_W-1:0] n_py;
    logic [POP_W+RATE_W-1:0] n_px;

    assign n_sum = N_W'(i_pt[C_S]) + N_W'(i_pt[C_I]) + N_W'(i_pt[C_R]);

    always_comb begin
        logic [REM_W-1:0] rem2;
        logic             ge;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            rem2     = {r_rem[k-1][REM_W-2:0], 1'b0};
            ge       = rem2 >= REM_W'(r_n[k-1]);
            n_rem[k] = ge ? rem2 - REM_W'(r_n[k-1]) : rem2;
            n_q[k]   = {r_q[k-1][POP_W-2:0], ge};
        end
    end

    always_comb begin
        n_qq = r_full[DIV_STEPS] ? (Q_W'(1) << POP_W) : {1'b0, r_q[DIV_STEPS]};
        n_pt = (POP_W+Q_W)'(r_i[DIV_STEPS]) * (POP_W+Q_W)'(n_qq);
        n_py = (POP_W+RATE_W)'(r_i[DIV_STEPS]) * (POP_W+RATE_W)'(i_alpha);
        n_px = (POP_W+RATE_W)'(r_t) * (POP_W+RATE_W)'(i_beta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= i_vld;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
            r_m1_vld <= r_dv_vld[DIV_STEPS];
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= REM_W'(i_pt[C_S]);
            r_q[0]     <= '0;
            r_n[0]     <= n_sum;
            r_i[0]     <= i_pt[C_I];
            r_full[0]  <= N_W'(i_pt[C_S]) >= n_sum;
            r_nz[0]    <= n_sum != '0;
            r_dside[0] <= i_side;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_rem[k]   <= n_rem[k];
                r_q[k]     <= n_q[k];
                r_n[k]     <= r_n[k-1];
                r_i[k]     <= r_i[k-1];
                r_full[k]  <= r_full[k-1];
                r_nz[k]    <= r_nz[k-1];
                r_dside[k] <= r_dside[k-1];
            end
            r_t       <= n_pt[2*POP_W-1:POP_W];
            r_y       <= n_py[POP_W+RATE_W-1:RATE_FRAC];
            r_m1_nz   <= r_nz[DIV_STEPS];
            r_m1_side <= r_dside[DIV_STEPS];
            r_x       <= r_m1_nz ? n_px[POP_W+RATE_W-1:RATE_FRAC] : '0;
            r_y2      <= r_y;
            r_m2_side <= r_m1_side;
        end
    end

    assign o_vld    = r_m2_vld;
    assign o_side   = r_m2_side;
    assign o_k[C_S] = K_W'(0) - {1'b0, r_x};
    assign o_k[C_I] = {1'b0, r_x} - {1'b0, r_y2};
    assign o_k[C_R] = {1'b0, r_y2};

endmodule

`default_nettype wire

// ----- rtl/sir_rk4_step.sv -----
// channel   direction  handshake                  beat
// input     in         i_valid / o_stall          i_susceptible, i_infected, i_recovered
// output    out        o_valid / i_stall          o_*_next, o_clamped
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one beat a cycle in, one beat a cycle out while the output beat is not stalled; pipeline
// of four derivative units of 35 stages each, set by the 32-stage s/n divider,
// three 3-stage stage-point units, 3 combine stages, 5 divide-by-3 stages, output
// synchronous active-low reset clears valid bits and loads register defaults
// the whole pipeline holds only while the output beat is stalled

`default_nettype none

module sir_rk4_step import srk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [POP_W-1:0]  i_susceptible,
    input  logic [POP_W-1:0]  i_infected,
    input  logic [POP_W-1:0]  i_recovered,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [POP_W-1:0]  o_susceptible_next,
    output logic [POP_W-1:0]  o_infected_next,
    output logic [POP_W-1:0]  o_recovered_next,
    output logic              o_clamped,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [RATE_W-1:0] i_cfg_data
);

    logic [RATE_W-1:0] r_beta;
    logic [RATE_W-1:0] r_alpha;
    logic [H_W-1:0]    r_h;
    logic              en;
    t_tri              in_pt;
    t_side             in_side;

    wire         d_vld  [0:3];
    wire t_ktri  d_k    [0:3];
    wire t_side  d_side [0:3];
    wire         sp_vld  [0:2];
    wire t_tri   sp_pt   [0:2];
    wire t_side  sp_side [0:2];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta  <= '0;
            r_alpha <= '0;
            r_h     <= H_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BETA:  r_beta  <= i_cfg_data;
                CFG_ALPHA: r_alpha <= i_cfg_data;
                CFG_STEP:  r_h     <= i_cfg_data[H_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_out_vld;
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    always_comb begin
        in_pt[C_S] = i_susceptible;
        in_pt[C_I] = i_infected;
        in_pt[C_R] = i_recovered;
        in_side    = '0;
        in_side.p  = in_pt;
    end

    // derivative units
    for (genvar g = 0; g < 4; g++) begin : g_deriv
        if (g == 0) begin : g_first
            srk_deriv u_deriv (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_vld   (i_valid),
                .i_pt    (in_pt),
                .i_side  (in_side),
                .i_beta  (r_beta),
                .i_alpha (r_alpha),
                .o_vld   (d_vld[g]),
                .o_k     (d_k[g]),
                .o_side  (d_side[g])
            );
        end else begin : g_next
            srk_deriv u_deriv (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_vld   (sp_vld[g-1]),
                .i_pt    (sp_pt[g-1]),
                .i_side  (sp_side[g-1]),
                .i_beta  (r_beta),
                .i_alpha (r_alpha),
                .o_vld   (d_vld[g]),
                .o_k     (d_k[g]),
                .o_side  (d_side[g])
            );
        end
    end

    // stage points p + (h/2)k1, p + (h/2)k2, p + h k3
    for (genvar g = 0; g < 3; g++) begin : g_stage
        localparam int SH = (g < 2) ? H_FRAC + 1 : H_FRAC;

        logic                          r_v1, r_v2, r_v3;
        logic [NCOMP-1:0][K_W-2:0]     r_mag;
        logic [NCOMP-1:0]              r_neg1, r_neg2;
        logic [NCOMP-1:0][K_W-2:0]     r_d;
        t_tri                          r_pt;
        t_side                         r_side1, r_side2, r_side3;
        t_side                         n_side;
        logic [NCOMP-1:0][K_W-2:0]     n_mag;
        logic [NCOMP-1:0][K_W-2:0]     n_d;
        t_tri                          n_pt;

        always_comb begin
            logic [K_W-1:0]         neg_k;
            logic [K_W+H_W-2:0]     prod;
            logic signed [K_W:0]    v;
            n_side = d_side[g];
            if (g == 0) begin
                n_side.k1 = d_k[g];
            end else if (g == 1) begin
                n_side.k2 = d_k[g];
            end else begin
                n_side.k3 = d_k[g];
            end
            for (int c = 0; c < NCOMP; c++) begin
                neg_k    = K_W'(0) - d_k[g][c];
                n_mag[c] = d_k[g][c][K_W-1] ? neg_k[K_W-2:0] : d_k[g][c][K_W-2:0];
                prod     = (K_W+H_W-1)'(r_mag[c]) * (K_W+H_W-1)'(r_h);
                n_d[c]   = (K_W-1)'(prod >> SH);
                if (r_neg2[c]) begin
                    v = $signed({{(K_W+1-POP_W){1'b0}}, r_side2.p[c]})
                      - $signed({2'b00, r_d[c]});
                end else begin
                    v = $signed({{(K_W+1-POP_W){1'b0}}, r_side2.p[c]})
                      + $signed({2'b00, r_d[c]});
                end
                if (v[K_W]) begin
                    n_pt[c] = '0;
                end else if (|v[K_W-1:POP_W]) begin
                    n_pt[c] = '1;
                end else begin
                    n_pt[c] = v[POP_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
                r_v3 <= 1'b0;
            end else if (en) begin
                r_v1 <= d_vld[g];
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mag   <= n_mag;
                for (int c = 0; c < NCOMP; c++) begin
                    r_neg1[c] <= d_k[g][c][K_W-1];
                end
                r_side1 <= n_side;
                r_d     <= n_d;
                r_neg2  <= r_neg1;
                r_side2 <= r_side1;
                r_pt    <= n_pt;
                r_side3 <= r_side2;
            end
        end

        assign sp_vld[g]  = r_v3;
        assign sp_pt[g]   = r_pt;
        assign sp_side[g] = r_side3;
    end

    // combine k1 + 2k2 + 2k3 + k4, scale by h/6
    function automatic logic signed [SUM_W-1:0] sx(input t_k k);
        sx = {{(SUM_W-K_W){k[K_W-1]}}, k};
    endfunction

    logic                            r_f1_vld, r_f2_vld;
    logic [NCOMP-1:0][SUM_W-1:0]     r_sum;
    logic [NCOMP-1:0][MAG_W-1:0]     r_fmag;
    logic [NCOMP-1:0]                r_fneg;
    t_tri                            r_f1_p, r_f2_p;

    logic                            r_dvld [0:D3_STAGES];
    logic [NCOMP-1:0][W3_W-1:0]      r_dw   [0:D3_STAGES];
    logic [NCOMP-1:0][1:0]           r_drem [0:D3_STAGES];
    logic [NCOMP-1:0]                r_dneg [0:D3_STAGES];
    t_tri                            r_dp   [0:D3_STAGES];

    logic [NCOMP-1:0][SUM_W-1:0]     n_sum;
    logic [NCOMP-1:0][MAG_W-1:0]     n_fmag;
    logic [NCOMP-1:0][W3_W-1:0]      n_w0;
    logic [NCOMP-1:0][W3_W-1:0]      n_dw   [1:D3_STAGES];
    logic [NCOMP-1:0][1:0]           n_drem [1:D3_STAGES];
    t_tri                            n_out;
    logic                            n_clamp;

    t_tri                            r_out;
    logic                            r_clamp;

    always_comb begin
        logic [SUM_W-1:0]       neg_sum;
        logic [MAG_W+H_W-1:0]   prod;
        for (int c = 0; c < NCOMP; c++) begin
            n_sum[c] = sx(d_side[3].k1[c]) + (sx(d_side[3].k2[c]) <<< 1)
                     + (sx(d_side[3].k3[c]) <<< 1) + sx(d_k[3][c]);
            neg_sum   = SUM_W'(0) - r_sum[c];
            n_fmag[c] = r_sum[c][SUM_W-1] ? neg_sum[MAG_W-1:0] : r_sum[c][MAG_W-1:0];
            prod      = (MAG_W+H_W)'(r_fmag[c]) * (MAG_W+H_W)'(r_h);
            n_w0[c]   = W3_W'(prod >> (H_FRAC + 1));
        end
    end

    // divide by three, D3_STEP quotient bits per stage
    always_comb begin
        logic [2:0]      r3;
        logic [1:0]      rem;
        logic [W3_W-1:0] w;
        int              bi;
        for (int st = 1; st <= D3_STAGES; st++) begin
            for (int c = 0; c < NCOMP; c++) begin
                rem = r_drem[st-1][c];
                w   = r_dw[st-1][c];
                for (int j = 0; j < D3_STEP; j++) begin
                    bi = W3_W - 1 - ((st - 1) * D3_STEP + j);
                    if (bi >= 0) begin
                        r3 = {rem, w[bi]};
                        if (r3 >= 3'd3) begin
                            r3    = r3 - 3'd3;
                            w[bi] = 1'b1;
                        end else begin
                            w[bi] = 1'b0;
                        end
                        rem = r3[1:0];
                    end
                end
                n_dw[st][c]   = w;
                n_drem[st][c] = rem;
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] v;
        n_clamp = 1'b0;
        for (int c = 0; c < NCOMP; c++) begin
            if (r_dneg[D3_STAGES][c]) begin
                v = $signed({{(SUM_W-POP_W){1'b0}}, r_dp[D3_STAGES][c]})
                  - $signed({2'b00, r_dw[D3_STAGES][c]});
            end else begin
                v = $signed({{(SUM_W-POP_W){1'b0}}, r_dp[D3_STAGES][c]})
                  + $signed({2'b00, r_dw[D3_STAGES][c]});
            end
            if (v[SUM_W-1]) begin
                n_out[c] = '0;
                n_clamp  = 1'b1;
            end else if (|v[SUM_W-2:POP_W]) begin
                n_out[c] = '1;
                n_clamp  = 1'b1;
            end else begin
                n_out[c] = v[POP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            for (int st = 0; st <= D3_STAGES; st++) begin
                r_dvld[st] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_f1_vld  <= d_vld[3];
            r_f2_vld  <= r_f1_vld;
            r_dvld[0] <= r_f2_vld;
            for (int st = 1; st <= D3_STAGES; st++) begin
                r_dvld[st] <= r_dvld[st-1];
            end
            r_out_vld <= r_dvld[D3_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum     <= n_sum;
            r_f1_p    <= d_side[3].p;
            r_fmag    <= n_fmag;
            for (int c = 0; c < NCOMP; c++) begin
                r_fneg[c] <= r_sum[c][SUM_W-1];
            end
            r_f2_p    <= r_f1_p;
            r_dw[0]   <= n_w0;
            r_drem[0] <= '0;
            r_dneg[0] <= r_fneg;
            r_dp[0]   <= r_f2_p;
            for (int st = 1; st <= D3_STAGES; st++) begin
                r_dw[st]   <= n_dw[st];
                r_drem[st] <= n_drem[st];
                r_dneg[st] <= r_dneg[st-1];
                r_dp[st]   <= r_dp[st-1];
            end
            r_out   <= n_out;
            r_clamp <= n_clamp;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_susceptible_next = r_out[C_S];
    assign o_infected_next    = r_out[C_I];
    assign o_recovered_next   = r_out[C_R];
    assign o_clamped          = r_clamp;

endmodule

`default_nettype wire

// ----- rtl/srk_check.sv -----
`default_nettype none

module srk_check import srk_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [POP_W-1:0] o_susceptible_next,
    input logic [POP_W-1:0] o_infected_next,
    input logic [POP_W-1:0] o_recovered_next,
    input logic             o_clamped
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_susceptible_next)
            && $stable(o_infected_next) && $stable(o_recovered_next)
            && $stable(o_clamped))
        else $error("stalled result beat changed");

    // input side only backs up when the result beat is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

    // a saturated result sits on one of the range limits
    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamped |->
            o_susceptible_next == '0 || o_susceptible_next == {POP_W{1'b1}} ||
            o_infected_next == '0 || o_infected_next == {POP_W{1'b1}} ||
            o_recovered_next == '0 || o_recovered_next == {POP_W{1'b1}})
        else $error("clamped result not at a limit");

endmodule

bind sir_rk4_step srk_check u_srk_check (.*);

`default_nettype wire
